// ===== hw/rtl/frti_pkg.sv =====
// Package: opcodes, precision codes and format constants for round-to-integral.
`timescale 1ns / 1ps
`default_nettype none
package frti_pkg;
   typedef enum logic [1:0] {
      OP_RINT   = 2'd0,
      OP_ROUND  = 2'd1,
      OP_NEARBY = 2'd2,
      OP_RSVD   = 2'd3
   } opcode_type;

   localparam logic PREC_DOUBLE = 1'b0;
   localparam logic PREC_SINGLE = 1'b1;

   localparam int unsigned DFRAC = 52;
   localparam int unsigned SFRAC = 23;
   localparam logic [10:0] DBIAS = 11'h3ff;
   localparam logic [7:0]  SBIAS = 8'h7f;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        precision;
      logic [63:0] operand_bits;
   } req_type;

   typedef struct packed {
      logic [63:0] result_bits;
      logic        inexact;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/frti_if.sv =====
// Valid/ready channel interface carrying a request or response payload.
`timescale 1ns / 1ps
`default_nettype none
interface frti_req_if;
   logic                 valid;
   logic                 ready;
   frti_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface frti_rsp_if;
   logic                 valid;
   logic                 ready;
   frti_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/frti_round.sv =====
// Combinational rounding datapath for binary64 and binary32.
`timescale 1ns / 1ps
`default_nettype none
module frti_round (
   input  frti_pkg::req_type req,
   output frti_pkg::rsp_type rsp
);
   import frti_pkg::*;

   logic        away;
   logic        sgl;
   logic [63:0] bits;
   logic [63:0] signb;
   logic [63:0] mag;
   logic [10:0] e;
   logic [11:0] bias;
   logic [5:0]  fw;
   logic [63:0] onebits;
   logic [63:0] fracmask;
   logic [11:0] kk;
   logic [5:0]  k;
   logic [63:0] mask;
   logic [63:0] frac;
   logic [63:0] half;
   logic [63:0] trunc;
   logic        lsb;
   logic        up;
   logic        is_half;
   logic [63:0] res;
   logic        inx;

   always_comb begin
      away  = (req.opcode == OP_ROUND);
      sgl   = (req.precision == PREC_SINGLE);
      if (sgl) begin
         bits     = {32'd0, req.operand_bits[31:0]};
         signb    = {32'd0, req.operand_bits[31], 31'd0};
         mag      = {33'd0, req.operand_bits[30:0]};
         e        = {3'd0, req.operand_bits[30:23]};
         bias     = {4'd0, SBIAS};
         fw       = 6'(SFRAC);
         onebits  = {33'd0, SBIAS, 23'd0};
         fracmask = {41'd0, {23{1'b1}}};
      end else begin
         bits     = req.operand_bits;
         signb    = {req.operand_bits[63], 63'd0};
         mag      = {1'b0, req.operand_bits[62:0]};
         e        = req.operand_bits[62:52];
         bias     = {1'b0, DBIAS};
         fw       = 6'(DFRAC);
         onebits  = {1'b0, DBIAS, 52'd0};
         fracmask = {12'd0, {52{1'b1}}};
      end
      kk    = bias + {6'd0, fw} - {1'b0, e};
      k     = kk[5:0];
      mask  = (64'd1 << k) - 64'd1;
      frac  = mag & mask;
      half  = 64'd1 << (k - 6'd1);
      trunc = mag & ~mask;
      lsb   = (k == fw) ? 1'b1 : trunc[k];
      is_half = 1'b0;
      up    = 1'b0;
      res   = bits;
      inx   = 1'b0;
      if ({1'b0, e} >= bias + {6'd0, fw} || mag == 64'd0) begin
         res = bits;
      end else if ({1'b0, e} < bias) begin
         is_half = ({1'b0, e} == bias - 12'd1) && ((mag & fracmask) == 64'd0);
         up  = (({1'b0, e} == bias - 12'd1) && !is_half) || (is_half && away);
         inx = 1'b1;
         res = signb | (up ? onebits : 64'd0);
      end else if (frac != 64'd0) begin
         inx = 1'b1;
         if (frac > half)       up = 1'b1;
         else if (frac == half) up = away || lsb;
         res = signb | (up ? trunc + (64'd1 << k) : trunc);
      end
      rsp.result_bits = res;
      rsp.inexact     = inx && (req.opcode != OP_NEARBY);
   end
endmodule
`default_nettype wire

// ===== hw/rtl/fp_round_to_integral_unit.sv =====
// Top level: registered single-pass round-to-integral unit.
// Registers: the request is held in the input reg, its result in the output reg.
// Throughput: one request per cycle unless stalled; rounding is one combinational pass.
// Stalls propagate stage by stage; each register loads when empty or draining.
// Reset (synchronous, active high) clears both stage valid flags only.
`timescale 1ns / 1ps
`default_nettype none
module fp_round_to_integral_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   frti_req_if.sink   req,
   frti_rsp_if.source rsp
);
   import frti_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;
   rsp_type calc;
   logic    out_load;
   logic    in_load;

   // output stage frees when empty or taken this cycle
   assign out_load = !out_vld_ff || rsp.ready;
   // input stage frees when empty or moving into output stage
   assign in_load  = !in_vld_ff || out_load;
   assign req.ready = in_load;

   frti_round u_round (.req(in_ff), .rsp(calc));

   always_comb begin
      in_vld_in  = in_load ? req.valid : in_vld_ff;
      out_vld_in = out_load ? in_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req.valid) in_ff <= req.payload;
      if (out_load && in_vld_ff) out_ff <= calc;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire
